[rtl/core/mhpq_pkg.sv]
package mhpq_pkg;

  // Number of entries the heap store holds.
  localparam int CAPACITY = 1024;
  // Address width of the store, width of the entry count and of child indexes.
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = ADDR_W + 2;
  localparam int KEY_W  = 32;
  localparam int COUNT_OUT_W = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP
  } state_e;

endpackage

[rtl/core/max_heap_priority_queue_unit.sv]
// Binary max-heap priority queue of signed 32-bit keys. An item (cmd_i, value_i) is
// taken at a rising edge where start is high and busy is low; busy then stays high
// until the item finishes, unless the item finishes in the idle state, and its single
// result appears on status_o, count_o, top_valid_o and top_value_o for exactly one
// cycle while done_o is high. The receiver cannot stall: a result must be captured
// in its done_o cycle or it is lost. An insert sifts the new key up level by level
// (parent read, then compare and write); a remove first fetches the last entry and
// then sifts it down level by level (left child read, right child read, compare and
// write). The store's single read port and the one shared signed comparator set
// these steps. An insert into a full heap, a remove from an empty heap and the
// removal of the only entry finish without leaving the idle state. No clearing
// pass is needed after reset: only entries below the count are ever read.
module max_heap_priority_queue_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic signed [31:0]           value_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [10:0]                  count_o,
  output logic                         top_valid_o,
  output logic signed [31:0]           top_value_o
);

  localparam int AW = mhpq_pkg::ADDR_W;
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int IW = mhpq_pkg::IDX_W;
  localparam int KW = mhpq_pkg::KEY_W;
  localparam int COUNT_PAD = mhpq_pkg::COUNT_OUT_W;

  mhpq_pkg::state_e  state_q, state_d;
  mhpq_pkg::status_e status_q, status_d;
  logic [CW-1:0]     count_q, count_d;
  logic              done_q, done_d;

  // Datapath registers: the key being moved, the hole position, and the best
  // candidate found so far during a sift-down level.
  logic [KW-1:0]     key_q, key_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [KW-1:0]     bv_q, bv_d;
  logic [AW-1:0]     best_q, best_d;
  logic [KW-1:0]     top_q;

  // Store port signals.
  logic              we;
  logic [AW-1:0]     waddr;
  logic [KW-1:0]     wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [KW-1:0]     rdata;

  // The shared comparator. During a sift-up compare it asks whether the key is
  // greater than its parent; otherwise it judges the read data against the
  // moving key, or against the better candidate when the right child is judged.
  logic [KW-1:0]     cmp_a;
  logic [KW-1:0]     cmp_b;
  logic              cmp_gt;

  logic [IW-1:0]     n_ext;
  logic [IW-1:0]     left_idx;
  logic [IW-1:0]     right_idx;
  logic              left_ok;
  logic              right_ok;
  logic [AW-1:0]     parent_idx;
  logic              full;
  logic [CW+COUNT_PAD-1:0] count_ext;

  mhpq_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cmp_a  = (state_q == mhpq_pkg::S_UP_CMP) ? key_q : rdata;
  assign cmp_b  = (state_q == mhpq_pkg::S_UP_CMP) ? rdata :
                  (state_q == mhpq_pkg::S_DN_CMP) ? bv_q : key_q;
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  assign n_ext      = {{(IW - CW){1'b0}}, count_q};
  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = left_idx + {{(IW - 1){1'b0}}, 1'b1};
  assign left_ok    = left_idx < n_ext;
  assign right_ok   = right_idx < n_ext;
  assign parent_idx = (pos_q - {{(AW - 1){1'b0}}, 1'b1}) >> 1;
  assign full       = (count_q == CW'(mhpq_pkg::CAPACITY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mhpq_pkg::S_IDLE;
      status_q <= mhpq_pkg::ST_DONE;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pos_q  <= pos_d;
    bv_q   <= bv_d;
    best_q <= best_d;
  end

  // Copy of the root, kept so the maximum is visible without a store read.
  always_ff @(posedge clk_i) begin
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    count_d  = count_q;
    done_d   = 1'b0;
    key_d    = key_q;
    pos_d    = pos_q;
    bv_d     = bv_q;
    best_d   = best_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = key_q;
    re       = 1'b0;
    raddr    = pos_q;

    case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (start) begin
          if (cmd_i == mhpq_pkg::CMD_INSERT) begin
            if (full) begin
              status_d = mhpq_pkg::ST_FULL;
              done_d   = 1'b1;
            end else begin
              status_d = mhpq_pkg::ST_DONE;
              key_d    = value_i;
              pos_d    = count_q[AW-1:0];
              count_d  = count_q + {{(CW - 1){1'b0}}, 1'b1};
              state_d  = mhpq_pkg::S_UP_CHK;
            end
          end else begin
            if (count_q == '0) begin
              status_d = mhpq_pkg::ST_EMPTY;
              done_d   = 1'b1;
            end else begin
              status_d = mhpq_pkg::ST_DONE;
              count_d  = count_q - {{(CW - 1){1'b0}}, 1'b1};
              pos_d    = '0;
              if (count_q == {{(CW - 1){1'b0}}, 1'b1}) begin
                // Removing the only entry leaves nothing to reorder.
                done_d = 1'b1;
              end else begin
                // Fetch the last entry; it becomes the key that sifts down.
                re      = 1'b1;
                raddr   = count_d[AW-1:0];
                state_d = mhpq_pkg::S_DN_LAST;
              end
            end
          end
        end
      end

      mhpq_pkg::S_UP_CHK: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          done_d  = 1'b1;
          state_d = mhpq_pkg::S_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = parent_idx;
          state_d = mhpq_pkg::S_UP_CMP;
        end
      end

      mhpq_pkg::S_UP_CMP: begin
        we = 1'b1;
        // The key moves up only when it is strictly greater than its parent.
        if (cmp_gt) begin
          wdata   = rdata;
          pos_d   = parent_idx;
          state_d = mhpq_pkg::S_UP_CHK;
        end else begin
          wdata   = key_q;
          done_d  = 1'b1;
          state_d = mhpq_pkg::S_IDLE;
        end
      end

      mhpq_pkg::S_DN_LAST: begin
        key_d   = rdata;
        state_d = mhpq_pkg::S_DN_L;
      end

      mhpq_pkg::S_DN_L: begin
        if (left_ok) begin
          re      = 1'b1;
          raddr   = left_idx[AW-1:0];
          state_d = mhpq_pkg::S_DN_R;
        end else begin
          we      = 1'b1;
          done_d  = 1'b1;
          state_d = mhpq_pkg::S_IDLE;
        end
      end

      mhpq_pkg::S_DN_R: begin
        // Left child is in the read register: judge it against the key.
        if (cmp_gt) begin
          bv_d   = rdata;
          best_d = left_idx[AW-1:0];
        end else begin
          bv_d   = key_q;
          best_d = pos_q;
        end
        if (right_ok) begin
          re    = 1'b1;
          raddr = right_idx[AW-1:0];
        end
        state_d = mhpq_pkg::S_DN_CMP;
      end

      mhpq_pkg::S_DN_CMP: begin
        we = 1'b1;
        if (right_ok && cmp_gt) begin
          // Right child strictly beats the better of key and left child.
          wdata   = rdata;
          pos_d   = right_idx[AW-1:0];
          state_d = mhpq_pkg::S_DN_L;
        end else if (best_q != pos_q) begin
          wdata   = bv_q;
          pos_d   = best_q;
          state_d = mhpq_pkg::S_DN_L;
        end else begin
          wdata   = key_q;
          done_d  = 1'b1;
          state_d = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_q != mhpq_pkg::S_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign count_ext = {{COUNT_PAD{1'b0}}, count_q};
  assign count_o   = count_ext[COUNT_PAD-1:0];
  assign top_valid_o = (count_q != '0);
  assign top_value_o = (count_q != '0) ? top_q : '0;

endmodule

[rtl/core/mhpq_store.sv]
module mhpq_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [mhpq_pkg::ADDR_W-1:0] waddr_i,
  input  logic [mhpq_pkg::KEY_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [mhpq_pkg::ADDR_W-1:0] raddr_i,
  output logic [mhpq_pkg::KEY_W-1:0]  rdata_o
);

  logic [mhpq_pkg::KEY_W-1:0] mem [mhpq_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered and holds its value between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[tb/sv/tb_max_heap_priority_queue_unit.sv]
`timescale 1ns / 100ps

module tb_max_heap_priority_queue_unit;

  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles the run goes on after the last predicted result before it ends.
  localparam int TAIL_CYCLES = 40;
  // Entry count the heap is grown to during the heavy idling part.
  localparam int GROW_TARGET = 200;

  // One entry of the stimulus queue. A pause entry makes the driver hold off
  // until every predicted result has come back from the block.
  typedef struct {
    logic                               pause;
    logic                               op;
    logic signed [mhpq_pkg::KEY_W-1:0]  key;
    int                                 idle_pct;
  } heap_request_t;

  typedef struct {
    mhpq_pkg::status_e                  status;
    logic [mhpq_pkg::COUNT_OUT_W-1:0]   count;
    logic                               top_valid;
    logic signed [mhpq_pkg::KEY_W-1:0]  top_value;
  } heap_outcome_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               cmd_i = mhpq_pkg::CMD_INSERT;
  logic signed [mhpq_pkg::KEY_W-1:0]  value_i = '0;
  logic                               done_o;
  logic [1:0]                         status_o;
  logic [10:0]                        count_o;
  logic                               top_valid_o;
  logic signed [mhpq_pkg::KEY_W-1:0]  top_value_o;

  heap_request_t            requests[$];
  heap_outcome_t            outcomes_due[$];

  // Shadow of the heap, kept in level order with the root at index zero.
  logic signed [mhpq_pkg::KEY_W-1:0]  shadow_keys [mhpq_pkg::CAPACITY];
  int                       shadow_held = 0;

  // Entry count as seen by the stimulus builder, used to plan fills.
  int                       planned_held = 0;
  int                       mismatch_count = 0;
  int                       cycle_count = 0;
  logic                     item_taken = 1'b0;

  max_heap_priority_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .top_valid_o (top_valid_o),
    .top_value_o (top_value_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic swap_keys(input int a, input int b);
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    tmp = shadow_keys[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_keys[b] = tmp;
  endtask

  // Applies one item to the shadow heap and returns the result the block owes.
  task automatic predict_heap_op(input logic op,
                                 input logic signed [mhpq_pkg::KEY_W-1:0] key,
                                 output heap_outcome_t res);
    int pos;
    int parent;
    int left;
    int right;
    int best;
    res.status = mhpq_pkg::ST_DONE;
    if (op == mhpq_pkg::CMD_INSERT) begin
      if (shadow_held >= mhpq_pkg::CAPACITY) begin
        res.status = mhpq_pkg::ST_FULL;
      end else begin
        pos = shadow_held;
        shadow_keys[pos] = key;
        shadow_held++;
        // Climb while the parent is strictly smaller.
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_keys[pos] <= shadow_keys[parent]) break;
          swap_keys(pos, parent);
          pos = parent;
        end
      end
    end else if (shadow_held == 0) begin
      res.status = mhpq_pkg::ST_EMPTY;
    end else begin
      shadow_held--;
      shadow_keys[0] = shadow_keys[shadow_held];
      pos = 0;
      // Sink toward the larger child; the left child wins a tie.
      forever begin
        left = 2 * pos + 1;
        right = left + 1;
        best = pos;
        if (left < shadow_held && shadow_keys[left] > shadow_keys[best]) best = left;
        if (right < shadow_held && shadow_keys[right] > shadow_keys[best]) best = right;
        if (best == pos) break;
        swap_keys(pos, best);
        pos = best;
      end
    end
    res.count = mhpq_pkg::COUNT_OUT_W'(shadow_held);
    res.top_valid = (shadow_held > 0);
    res.top_value = (shadow_held > 0) ? shadow_keys[0] : '0;
  endtask

  // Keys mix full-range values with a narrow band and the extremes so that
  // ties and sign boundaries turn up often.
  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    logic signed [mhpq_pkg::KEY_W-1:0] k;
    case ($urandom_range(9))
      0, 1, 2, 3: k = $urandom;
      4, 5, 6:    k = $signed($urandom_range(16)) - 8;
      7: begin
        case ($urandom_range(3))
          0: k = 32'h7FFF_FFFF;
          1: k = 32'h8000_0000;
          2: k = 32'h0000_0000;
          default: k = 32'hFFFF_FFFF;
        endcase
      end
      default: k = $urandom & 32'h8000_00FF;
    endcase
    return k;
  endfunction

  task automatic queue_op(input logic op, input logic signed [mhpq_pkg::KEY_W-1:0] key,
                          input int idle_pct);
    heap_request_t r;
    r.pause = 1'b0;
    r.op = op;
    r.key = key;
    r.idle_pct = idle_pct;
    requests.insert(requests.size(), r);
    if (op == mhpq_pkg::CMD_INSERT && planned_held < mhpq_pkg::CAPACITY) planned_held++;
    if (op == mhpq_pkg::CMD_REMOVE && planned_held > 0) planned_held--;
  endtask

  task automatic queue_pause();
    heap_request_t r;
    r.pause = 1'b1;
    r.op = mhpq_pkg::CMD_INSERT;
    r.key = '0;
    r.idle_pct = 0;
    requests.insert(requests.size(), r);
  endtask

  task automatic queue_mixed(input int n, input int insert_pct, input int idle_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < insert_pct) queue_op(mhpq_pkg::CMD_INSERT, pick_key(), idle_pct);
      else queue_op(mhpq_pkg::CMD_REMOVE, $urandom, idle_pct);
    end
  endtask

  // Driver: a new item goes out at the falling edge, and start stays high until
  // the block has taken it. Pause entries wait for the block to fall silent.
  always @(negedge clk_i) begin : driver
    logic next_start;
    next_start = 1'b0;
    if (rst_ni) begin
      if (item_taken) void'(requests.pop_front());
      if (requests.size() > 0 && requests[0].pause &&
          outcomes_due.size() == 0 && !busy) begin
        void'(requests.pop_front());
      end
      if (requests.size() > 0 && !requests[0].pause) begin
        if (start && !item_taken) next_start = 1'b1;
        else next_start = ($urandom_range(99) >= requests[0].idle_pct);
        if (next_start) begin
          cmd_i <= requests[0].op;
          value_i <= requests[0].key;
        end
      end
    end
    start <= next_start;
  end

  // Monitor: results are checked at the rising edge that ends their cycle, and
  // an item taken at the same edge is predicted afterwards.
  always @(posedge clk_i) begin : monitor
    heap_outcome_t want;
    heap_outcome_t got;
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      if (done_o) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = outcomes_due.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status_o, want.status));
          if (count_o !== want.count)
            report_mismatch($sformatf("count %0d, predicted %0d", count_o, want.count));
          if (top_valid_o !== want.top_valid)
            report_mismatch($sformatf("top_valid %0b, predicted %0b",
                                      top_valid_o, want.top_valid));
          if (top_value_o !== want.top_value)
            report_mismatch($sformatf("top_value %0d, predicted %0d",
                                      top_value_o, want.top_value));
        end
      end
      if (start && !busy) begin
        predict_heap_op(cmd_i, value_i, got);
        outcomes_due.insert(outcomes_due.size(), got);
      end
      item_taken <= start && !busy;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_max_heap_priority_queue_unit: errors");
      $finish;
    end
  end

  initial begin
    // Directed part: removes on an empty heap, removing the only entry, the
    // key extremes, equal keys for the left-child tie, and draining to empty.
    queue_op(mhpq_pkg::CMD_REMOVE, 32'h1234_5678, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'sd5, 0);
    queue_op(mhpq_pkg::CMD_REMOVE, '0, 0);
    queue_op(mhpq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'h8000_0000, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'h0000_0000, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'sd7, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'sd7, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'sd7, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'h8000_0001, 0);
    queue_op(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFE, 0);
    repeat (9) queue_op(mhpq_pkg::CMD_REMOVE, '0, 0);
    queue_op(mhpq_pkg::CMD_REMOVE, 32'h5555_AAAA, 0);
    queue_pause();

    // Light sender idling with a mixed load that grows the heap.
    queue_mixed(250, 60, 18);
    queue_pause();

    // Heavy sender idling: grow the heap several levels deep, then work on it.
    while (planned_held < GROW_TARGET) queue_op(mhpq_pkg::CMD_INSERT, pick_key(), 57);
    queue_mixed(40, 50, 57);
    queue_pause();

    // No idling: mostly removes from a deep heap.
    queue_mixed(300, 35, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (requests.size() > 0 || start) @(posedge clk_i);
    while (outcomes_due.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outcomes_due.size() == 0) begin
      $display("tb_max_heap_priority_queue_unit: clean");
    end else begin
      $display("tb_max_heap_priority_queue_unit: errors");
    end
    $finish;
  end

endmodule
